FILE: hw/rtl/dslt_pkg.sv
package dslt_pkg;

    localparam int MaxInputs  = 15;
    localparam int MaxOutputs = 16;
    localparam int FracBits   = 12;
    localparam int WordBits   = 16;
    localparam int WRows      = MaxInputs + 1;
    localparam int WDepth     = WRows * MaxOutputs;
    localparam int WAddrBits  = $clog2(WDepth);
    localparam int RowBits    = 4;
    localparam int ColBits    = 4;
    localparam int AccBits    = 40;
    localparam int LrBits     = 16;

    localparam logic signed [WordBits-1:0] OneFx = WordBits'(1 << FracBits);

    typedef enum logic [2:0] {
        OP_LOAD_INPUT = 3'd0,
        OP_LOAD_WEIGHT = 3'd1,
        OP_LOAD_GRAD = 3'd2,
        OP_FORWARD = 3'd3,
        OP_BACKWARD = 3'd4,
        OP_UPDATE = 3'd5
    } t_op;

    localparam logic [1:0] REG_LR = 2'd0;
    localparam logic [1:0] REG_NIN = 2'd1;
    localparam logic [1:0] REG_NOUT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_MAC,
        ST_FIN0,
        ST_FIN1,
        ST_FIN2,
        ST_EMIT,
        ST_UPD0,
        ST_UPD1,
        ST_UPD2,
        ST_UPD3,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MODE_FWD,
        MODE_BWD,
        MODE_UPD
    } t_mode;

    typedef struct packed {
        logic       clear_acc;
        logic       mac;
        logic       fin0;
        logic       fin1;
        logic       fin2;
        logic       upd0;
        logic       upd1;
        logic       upd2;
        logic       upd_write;
        t_mode      mode;
        logic [RowBits-1:0] row;
        logic [ColBits-1:0] col;
        logic       bias_row;
        logic       done_result;
    } t_cmd;

    function automatic logic signed [WordBits-1:0] sat_word(input logic signed [AccBits-1:0] v);
        logic signed [AccBits-1:0] hi;
        logic signed [AccBits-1:0] lo;
        hi = AccBits'((64'sd1 <<< (WordBits - 1)) - 1);
        lo = -hi - 1;
        if (v > hi) return hi[WordBits-1:0];
        if (v < lo) return lo[WordBits-1:0];
        return v[WordBits-1:0];
    endfunction

    // round half up, then arithmetic shift
    function automatic logic signed [AccBits-1:0] round_shift(input logic signed [AccBits-1:0] v,
                                                              input int s);
        logic signed [AccBits:0] t;
        t = {v[AccBits-1], v} + ((AccBits+1)'(1) <<< (s - 1));
        t = t >>> s;
        return t[AccBits-1:0];
    endfunction

    function automatic logic signed [WordBits-1:0] sigmoid(input logic signed [WordBits-1:0] z);
        logic [WordBits:0] m;
        logic [WordBits:0] y;
        logic [WordBits:0] one;
        one = (WordBits+1)'(1 << FracBits);
        m = z[WordBits-1] ? (WordBits+1)'(-{z[WordBits-1], z}) : (WordBits+1)'({1'b0, z});
        if (m >= (WordBits+1)'(5 << FracBits)) y = one;
        else if (m >= (WordBits+1)'((19 << FracBits) >> 3))
            y = (m >> 5) + (WordBits+1)'((27 << FracBits) >> 5);
        else if (m >= one) y = (m >> 3) + (WordBits+1)'((5 << FracBits) >> 3);
        else y = (m >> 2) + (one >> 1);
        if (z[WordBits-1]) y = one - y;
        return y[WordBits-1:0];
    endfunction

endpackage

FILE: hw/rtl/dslt_stream_if.sv
interface dslt_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/dslt_ram.sv
module dslt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/dslt_datapath.sv
module dslt_datapath (
    input  logic                                 i_clk,
    input  dslt_pkg::t_cmd                       i_cmd,
    input  logic                                 i_load_we,
    input  dslt_pkg::t_op                        i_load_op,
    input  logic [dslt_pkg::RowBits-1:0]         i_load_row,
    input  logic [dslt_pkg::ColBits-1:0]         i_load_col,
    input  logic signed [dslt_pkg::WordBits-1:0] i_load_value,
    input  logic [dslt_pkg::LrBits-1:0]          i_lr,
    output logic signed [dslt_pkg::WordBits-1:0] o_result
);
    localparam int W = dslt_pkg::WordBits;
    localparam int A = dslt_pkg::AccBits;
    localparam int AB = dslt_pkg::WAddrBits;

    logic signed [W-1:0] r_x [dslt_pkg::MaxInputs];
    logic signed [W-1:0] r_g [dslt_pkg::MaxOutputs];
    logic signed [A-1:0] r_acc;
    logic signed [W-1:0] r_s;
    logic signed [W-1:0] r_d;
    logic signed [W-1:0] r_res;
    logic signed [W-1:0] r_t;
    logic signed [W-1:0] r_delta;
    logic signed [A-1:0] r_prod;

    logic                w_we;
    logic [AB-1:0]       w_waddr;
    logic [W-1:0]        w_wdata;
    logic [AB-1:0]       w_raddr;
    logic signed [W-1:0] w_rd;
    logic signed [W-1:0] w_xa;
    logic signed [W-1:0] w_op_b;
    logic signed [A-1:0] w_sum;
    logic signed [2*W+1:0] w_mul;

    assign w_raddr = {i_cmd.row, i_cmd.col};

    always_comb begin
        w_we    = i_cmd.upd_write;
        w_waddr = {i_cmd.row, i_cmd.col};
        w_wdata = dslt_pkg::sat_word(A'(w_rd) - A'(r_delta));
        if (i_load_we && i_load_op == dslt_pkg::OP_LOAD_WEIGHT) begin
            w_we    = 1'b1;
            w_waddr = {i_load_row, i_load_col};
            w_wdata = i_load_value;
        end
    end

    dslt_ram #(.WIDTH(W), .DEPTH(dslt_pkg::WDepth)) u_wram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rd)
    );

    assign w_xa = i_cmd.bias_row ? dslt_pkg::OneFx
                                 : r_x[i_cmd.row[3:0] == 4'd15 ? 4'd0 : i_cmd.row];
    assign w_op_b = (i_cmd.mode == dslt_pkg::MODE_FWD) ? w_xa : r_g[i_cmd.col];
    assign w_mul = (2*W+2)'(w_rd) * (2*W+2)'(w_op_b);

    always_comb begin
        w_sum = r_acc + A'(w_mul);
        if (r_acc[A-1] == w_mul[2*W+1] && w_sum[A-1] != r_acc[A-1]) begin
            w_sum = r_acc[A-1] ? {1'b1, {(A-1){1'b0}}} : {1'b0, {(A-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_we && i_load_op == dslt_pkg::OP_LOAD_INPUT
            && i_load_row != 4'(dslt_pkg::MaxInputs)) begin
            r_x[i_load_row] <= i_load_value;
        end
        if (i_load_we && i_load_op == dslt_pkg::OP_LOAD_GRAD) begin
            r_g[i_load_col] <= i_load_value;
        end
        if (i_cmd.clear_acc) begin
            r_acc <= '0;
        end else if (i_cmd.mac) begin
            r_acc <= w_sum;
        end
        if (i_cmd.fin0) begin
            r_s <= dslt_pkg::sat_word(dslt_pkg::round_shift(r_acc, dslt_pkg::FracBits));
            r_prod <= A'(w_xa) * (A'(dslt_pkg::OneFx) - A'(w_xa));
        end
        if (i_cmd.fin1) begin
            r_d <= dslt_pkg::sat_word(dslt_pkg::round_shift(r_prod, dslt_pkg::FracBits));
            if (i_cmd.mode == dslt_pkg::MODE_FWD) begin
                r_res <= dslt_pkg::sigmoid(r_s);
            end
        end
        if (i_cmd.fin2) begin
            r_res <= dslt_pkg::sat_word(dslt_pkg::round_shift(A'(r_s) * A'(r_d),
                                                              dslt_pkg::FracBits));
        end
        if (i_cmd.done_result) begin
            r_res <= '0;
        end
        if (i_cmd.upd0) begin
            r_prod <= A'(w_xa) * A'(r_g[i_cmd.col]);
        end
        if (i_cmd.upd1) begin
            r_t <= dslt_pkg::sat_word(dslt_pkg::round_shift(r_prod, dslt_pkg::FracBits));
        end
        if (i_cmd.upd2) begin
            r_delta <= W'(dslt_pkg::round_shift(A'(signed'({1'b0, i_lr})) * A'(r_t), 16));
        end
    end

    assign o_result = r_res;
endmodule

FILE: hw/rtl/dslt_ctrl.sv
module dslt_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  dslt_pkg::t_op                i_op,
    input  logic [4:0]                   i_nin,
    input  logic [4:0]                   i_nout,
    input  logic                         i_out_ready,
    output logic                         o_busy,
    output logic                         o_out_valid,
    output logic [dslt_pkg::RowBits-1:0] o_node,
    output logic                         o_last,
    output dslt_pkg::t_cmd               o_cmd
);
    dslt_pkg::t_state r_state, n_state;
    dslt_pkg::t_mode  r_mode, n_mode;
    logic [4:0] r_row, n_row;
    logic [4:0] r_col, n_col;
    logic [4:0] r_node, n_node;
    logic       r_last, n_last;
    logic       w_inner_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dslt_pkg::ST_IDLE;
            r_mode  <= dslt_pkg::MODE_FWD;
            r_row   <= '0;
            r_col   <= '0;
            r_node  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_row   <= n_row;
            r_col   <= n_col;
            r_node  <= n_node;
            r_last  <= n_last;
        end
    end

    // forward walks rows, backward walks columns
    assign w_inner_end = (r_mode == dslt_pkg::MODE_FWD) ? (r_row == i_nin)
                                                       : (r_col == i_nout - 5'd1);

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_row   = r_row;
        n_col   = r_col;
        n_node  = r_node;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.mode = r_mode;
        o_cmd.row  = r_row[3:0];
        o_cmd.col  = r_col[3:0];
        o_cmd.bias_row = (r_row == i_nin);
        o_out_valid = 1'b0;
        case (r_state)
            dslt_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_row = '0;
                    n_col = '0;
                    case (i_op)
                        dslt_pkg::OP_FORWARD: begin
                            n_mode = dslt_pkg::MODE_FWD;
                            n_state = dslt_pkg::ST_ISSUE;
                        end
                        dslt_pkg::OP_BACKWARD: begin
                            n_mode = dslt_pkg::MODE_BWD;
                            n_state = dslt_pkg::ST_ISSUE;
                        end
                        dslt_pkg::OP_UPDATE: begin
                            n_mode = dslt_pkg::MODE_UPD;
                            n_state = dslt_pkg::ST_UPD0;
                        end
                        default: n_state = dslt_pkg::ST_IDLE;
                    endcase
                    o_cmd.clear_acc = 1'b1;
                end
            end
            dslt_pkg::ST_ISSUE: begin
                n_state = dslt_pkg::ST_WAIT;
            end
            dslt_pkg::ST_WAIT: begin
                n_state = dslt_pkg::ST_MAC;
            end
            dslt_pkg::ST_MAC: begin
                o_cmd.mac = 1'b1;
                if (w_inner_end) begin
                    n_state = dslt_pkg::ST_FIN0;
                end else begin
                    n_state = dslt_pkg::ST_ISSUE;
                    if (r_mode == dslt_pkg::MODE_FWD) n_row = r_row + 5'd1;
                    else n_col = r_col + 5'd1;
                end
            end
            dslt_pkg::ST_FIN0: begin
                o_cmd.fin0 = 1'b1;
                n_state = dslt_pkg::ST_FIN1;
            end
            dslt_pkg::ST_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state = (r_mode == dslt_pkg::MODE_FWD) ? dslt_pkg::ST_EMIT
                                                         : dslt_pkg::ST_FIN2;
                n_node = (r_mode == dslt_pkg::MODE_FWD) ? r_col : r_row;
                n_last = (r_mode == dslt_pkg::MODE_FWD) ? (r_col == i_nout - 5'd1)
                                                        : (r_row == i_nin);
            end
            dslt_pkg::ST_FIN2: begin
                o_cmd.fin2 = 1'b1;
                n_state = dslt_pkg::ST_EMIT;
            end
            dslt_pkg::ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.clear_acc = 1'b1;
                    if (r_last) begin
                        n_state = dslt_pkg::ST_IDLE;
                    end else begin
                        n_state = dslt_pkg::ST_ISSUE;
                        if (r_mode == dslt_pkg::MODE_FWD) begin
                            n_row = '0;
                            n_col = r_col + 5'd1;
                        end else begin
                            n_col = '0;
                            n_row = r_row + 5'd1;
                        end
                    end
                end
            end
            // weight read issued, product, delta, write back
            dslt_pkg::ST_UPD0: begin
                o_cmd.upd0 = 1'b1;
                n_state = dslt_pkg::ST_UPD1;
            end
            dslt_pkg::ST_UPD1: begin
                o_cmd.upd1 = 1'b1;
                n_state = dslt_pkg::ST_UPD2;
            end
            dslt_pkg::ST_UPD2: begin
                o_cmd.upd2 = 1'b1;
                n_state = dslt_pkg::ST_UPD3;
            end
            dslt_pkg::ST_UPD3: begin
                o_cmd.upd_write = 1'b1;
                if (r_col == i_nout - 5'd1) begin
                    n_col = '0;
                    if (r_row == i_nin) begin
                        n_state = dslt_pkg::ST_DONE;
                        n_node = '0;
                        n_last = 1'b1;
                    end else begin
                        n_row = r_row + 5'd1;
                        n_state = dslt_pkg::ST_UPD0;
                    end
                end else begin
                    n_col = r_col + 5'd1;
                    n_state = dslt_pkg::ST_UPD0;
                end
            end
            dslt_pkg::ST_DONE: begin
                o_cmd.done_result = 1'b1;
                n_state = dslt_pkg::ST_EMIT;
            end
            default: n_state = dslt_pkg::ST_IDLE;
        endcase
    end

    assign o_busy = (r_state != dslt_pkg::ST_IDLE);
    assign o_node = r_node[3:0];
    assign o_last = r_last;
endmodule

FILE: hw/rtl/dense_sigmoid_layer_train_core.sv
// One sigmoid dense layer with SGD training in Q4.12. Loads (input, weight,
// gradient) give no beat. Forward and backward walk the 16x16 weight RAM
// through one shared multiply-accumulate; each weight passes the issue,
// wait (RAM read latency) and accumulate states, and each node then the
// finish states before its result beat. Update walks the states UPD0 to
// UPD3 per weight and ends with one done beat. One item is worked at a
// time; a result beat holds until taken. Input beat data: {operation,
// row_index, column_index, load_value}; output beat data: {node_index,
// result_value, last_result}.
module dense_sigmoid_layer_train_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    dslt_stream_if.sink   s_in,
    dslt_stream_if.source m_out
);
    logic [15:0] r_lr;
    logic [3:0]  r_nin;
    logic [4:0]  r_nout;
    logic [4:0]  w_nin;
    logic [4:0]  w_nout;
    logic        w_busy;
    logic        w_acc;
    logic        w_out_valid;
    logic [3:0]  w_node;
    logic        w_last;
    logic signed [15:0] w_res;
    dslt_pkg::t_cmd w_cmd;
    dslt_pkg::t_op  w_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr   <= 16'd656;
            r_nin  <= 4'd15;
            r_nout <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dslt_pkg::REG_LR:   r_lr <= i_cfg_data;
                dslt_pkg::REG_NIN:  r_nin <= i_cfg_data[3:0];
                dslt_pkg::REG_NOUT: r_nout <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign w_nin  = (r_nin == 4'd0) ? 5'd1 : {1'b0, r_nin};
    assign w_nout = (r_nout == 5'd0) ? 5'd1 : (r_nout > 5'd16 ? 5'd16 : r_nout);

    assign s_in.ready = !w_busy;
    assign w_acc = s_in.valid && s_in.ready;
    assign w_op  = dslt_pkg::t_op'(s_in.data[26:24]);

    dslt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_acc),
        .i_op       (w_op),
        .i_nin      (w_nin),
        .i_nout     (w_nout),
        .i_out_ready(m_out.ready),
        .o_busy     (w_busy),
        .o_out_valid(w_out_valid),
        .o_node     (w_node),
        .o_last     (w_last),
        .o_cmd      (w_cmd)
    );

    dslt_datapath u_dp (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_load_we   (w_acc),
        .i_load_op   (w_op),
        .i_load_row  (s_in.data[23:20]),
        .i_load_col  (s_in.data[19:16]),
        .i_load_value(s_in.data[15:0]),
        .i_lr        (r_lr),
        .o_result    (w_res)
    );

    assign m_out.valid = w_out_valid;
    assign m_out.data  = {w_node, w_res, w_last};
endmodule
